[hdl/rhd_pkg.sv]
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types and constants of the RTP H.264 depacketizer.
// ----------------------------------------------------------------------------
package rhd_pkg;

	localparam int LEN_BITS_DEF = 16;
	localparam int Q_DEPTH      = 4;
	localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);

	localparam logic [31:0] CLOCK_RATE_RST = 32'd90000;
	localparam logic [31:0] CLOCK_RATE_DEF = 32'd1000;

	localparam logic [4:0] NAL_SINGLE_MAX = 5'd5;
	localparam logic [4:0] NAL_DROP_MAX   = 5'd23;
	localparam logic [4:0] NAL_STAP_A     = 5'd24;
	localparam logic [4:0] NAL_FU_A       = 5'd28;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNSUP    = 2'd1,
		ST_FU_SHORT = 2'd2,
		ST_OVERRUN  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SKIP,
		PH_SINGLE,
		PH_AGG_HI,
		PH_AGG_LO,
		PH_AGG_NAL,
		PH_FU_HDR,
		PH_FU_BODY,
		PH_FU_BODY_END
	} phase_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_MUL,
		TS_DIV,
		TS_DONE
	} ts_state_t;

	// one request per input byte that yields results
	typedef struct packed {
		logic        sc;
		logic        has_byte;
		logic [7:0]  data;
		logic        has_stat;
		status_t     status;
		logic        fin;
		logic [31:0] time_ms;
	} cmd_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quot;
	} ts_stat_t;

endpackage

[hdl/rtp_h264_depacketizer_unit.sv]
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer_unit
// RTP H.264 payload bytes in, Annex B byte stream out.
// ----------------------------------------------------------------------------
// A byte that is not the first of a packet is taken unless the queue is full.
// The first byte of a packet with nonzero length also waits while the serial
// divider turns the extended timestamp into milliseconds, one quotient bit a
// cycle. Each accepted byte yields up to five results, one per cycle while
// res_stall is low, via a four-entry request queue, so the parser runs ahead.
module rtp_h264_depacketizer_unit import rhd_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        pkt_first,
	input  logic [15:0] packet_length,
	input  logic [31:0] rtp_timestamp,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        out_valid,
	output logic [7:0]  out_data,
	output logic        out_unit_start,
	output logic        out_unit_end,
	output logic [31:0] time_ms,
	output logic [1:0]  status,
	output logic        run_last
);

	logic [31:0]         clock_rate_q;
	logic [LEN_BITS-1:0] len;
	logic                new_pkt;
	logic                accept;
	logic                push, pop, empty, full;
	cmd_t                wcmd, rcmd;
	ts_stat_t            ts;

	assign cfg_ready = 1'b1;
	assign len       = packet_length[LEN_BITS-1:0];
	assign new_pkt   = pkt_first && (len != '0);
	assign in_stall  = full || (new_pkt && !ts.done);
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clock_rate_q <= CLOCK_RATE_RST;
		else if (cfg_valid && cfg_ready)
			clock_rate_q <= cfg_data;
	end

	rhd_tsdiv u_tsdiv (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_valid && new_pkt && !ts.busy && !ts.done),
		.ack           (accept && new_pkt),
		.rtp_timestamp (rtp_timestamp),
		.clock_rate    (clock_rate_q),
		.stat          (ts)
	);

	rhd_front #(.LEN_BITS(LEN_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.pkt_first (pkt_first),
		.len       (len),
		.quot      (ts.quot),
		.push      (push),
		.cmd       (wcmd)
	);

	rhd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wcmd),
		.pop    (pop),
		.rdata  (rcmd),
		.empty  (empty),
		.full   (full)
	);

	rhd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (rcmd),
		.empty          (empty),
		.pop            (pop),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.out_valid      (out_valid),
		.out_data       (out_data),
		.out_unit_start (out_unit_start),
		.out_unit_end   (out_unit_end),
		.time_ms        (time_ms),
		.status         (status),
		.run_last       (run_last)
	);

`ifndef SYNTHESIS
	a_pkt_needs_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && new_pkt) |-> ts.done) else $error("packet taken before ms ready");
	a_div_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && new_pkt) |=> !ts.done) else $error("divider not released");
	a_start_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_unit_start) |-> (out_valid && out_data == 8'd0))
		else $error("unit start not on start code");
`endif

endmodule

[hdl/rhd_tsdiv.sv]
// ----------------------------------------------------------------------------
// rhd_tsdiv
// Extended timestamp tracking and serial ms conversion, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rhd_tsdiv import rhd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        ack,
	input  logic [31:0] rtp_timestamp,
	input  logic [31:0] clock_rate,
	output ts_stat_t    stat
);

	ts_state_t   state_q, state_d;
	logic [63:0] ext_q;
	logic [31:0] prev_q;
	logic        seen_q;
	logic [31:0] div_q;
	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic        qbit;

	assign trial = {rem_q, dvd_q[63]};
	assign qbit  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			ext_q   <= '0;
			prev_q  <= '0;
			seen_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == TS_IDLE && start) begin
				ext_q  <= seen_q ? ext_q + {32'd0, rtp_timestamp - prev_q}
				                 : {32'd0, rtp_timestamp};
				prev_q <= rtp_timestamp;
				seen_q <= 1'b1;
			end
			if (state_q == TS_MUL)
				cnt_q <= '0;
			else if (state_q == TS_DIV)
				cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == TS_IDLE && start)
			div_q <= (clock_rate == '0) ? CLOCK_RATE_DEF : clock_rate;
		if (state_q == TS_MUL) begin
			dvd_q <= (ext_q << 10) - (ext_q << 4) - (ext_q << 3);
			rem_q <= '0;
		end else if (state_q == TS_DIV) begin
			dvd_q <= {dvd_q[62:0], qbit};
			rem_q <= qbit ? 32'(trial - {1'b0, div_q}) : trial[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: if (start) state_d = TS_MUL;
			TS_MUL:  state_d = TS_DIV;
			TS_DIV:  if (cnt_q == 6'd63) state_d = TS_DONE;
			TS_DONE: if (ack) state_d = TS_IDLE;
			default: state_d = TS_IDLE;
		endcase
		stat.busy = (state_q == TS_MUL) || (state_q == TS_DIV);
		stat.done = (state_q == TS_DONE);
		stat.quot = dvd_q[31:0];
	end

endmodule

[hdl/rhd_front.sv]
// ----------------------------------------------------------------------------
// rhd_front
// Packet parser: classifies each payload byte; bytes that yield results become emission requests.
// ----------------------------------------------------------------------------
module rhd_front import rhd_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic        pkt_first,
	input  logic [LEN_BITS-1:0] len,
	input  logic [31:0] quot,
	output logic        push,
	output cmd_t        cmd
);

	phase_t              phase_q, phase_d;
	logic [LEN_BITS-1:0] bl_q, bl_d;
	logic [LEN_BITS-1:0] nal_q, nal_d;
	logic [7:0]          hi_q, hi_d;
	logic [2:0]          nri_q, nri_d;
	logic [31:0]         time_q;
	logic [4:0]          typ;
	logic [15:0]         size;
	logic                mark;
	logic                boundary;

	assign typ  = in_byte[4:0];
	assign size = {hi_q, in_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bl_q    <= '0;
			nal_q   <= '0;
			hi_q    <= '0;
			nri_q   <= '0;
			time_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			bl_q    <= bl_d;
			nal_q   <= nal_d;
			hi_q    <= hi_d;
			nri_q   <= nri_d;
			if (pkt_first && len != '0)
				time_q <= quot;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		bl_d     = bl_q;
		nal_d    = nal_q;
		hi_d     = hi_q;
		nri_d    = nri_q;
		mark     = 1'b0;
		boundary = 1'b0;
		cmd      = '0;
		cmd.status  = ST_OK;
		cmd.time_ms = pkt_first ? quot : time_q;
		if (pkt_first) begin
			if (len == '0) begin
				phase_d = PH_IDLE;
				bl_d    = '0;
			end else begin
				bl_d = len - 1'b1;
				if (typ <= NAL_SINGLE_MAX) begin
					cmd.sc       = 1'b1;
					cmd.has_byte = 1'b1;
					cmd.data     = in_byte;
					mark         = (bl_d == '0);
					phase_d      = PH_SINGLE;
				end else if (typ <= NAL_DROP_MAX) begin
					phase_d = PH_SKIP;
				end else if (typ == NAL_STAP_A) begin
					boundary = 1'b1;
				end else if (typ == NAL_FU_A) begin
					if (len < LEN_BITS'(3)) begin
						cmd.has_stat = 1'b1;
						cmd.status   = ST_FU_SHORT;
						phase_d      = PH_SKIP;
					end else begin
						nri_d   = in_byte[7:5];
						phase_d = PH_FU_HDR;
					end
				end else begin
					cmd.has_stat = 1'b1;
					cmd.status   = ST_UNSUP;
					phase_d      = PH_SKIP;
				end
			end
		end else if (phase_q != PH_IDLE && bl_q != '0) begin
			bl_d = bl_q - 1'b1;
			unique case (phase_q)
				PH_SINGLE, PH_FU_BODY_END: begin
					cmd.has_byte = 1'b1;
					cmd.data     = in_byte;
					mark         = (bl_d == '0);
				end
				PH_FU_BODY: begin
					cmd.has_byte = 1'b1;
					cmd.data     = in_byte;
				end
				PH_AGG_HI: begin
					hi_d    = in_byte;
					phase_d = PH_AGG_LO;
				end
				PH_AGG_LO: begin
					if (size > 16'(bl_d)) begin
						cmd.has_stat = 1'b1;
						cmd.status   = ST_OVERRUN;
						mark         = 1'b1;
						phase_d      = PH_SKIP;
					end else begin
						cmd.sc = 1'b1;
						nal_d  = size[LEN_BITS-1:0];
						if (size == 16'd0)
							boundary = 1'b1;
						else
							phase_d = PH_AGG_NAL;
					end
				end
				PH_AGG_NAL: begin
					cmd.has_byte = 1'b1;
					cmd.data     = in_byte;
					nal_d        = nal_q - 1'b1;
					if (nal_d == '0)
						boundary = 1'b1;
				end
				PH_FU_HDR: begin
					if (in_byte[7]) begin
						cmd.sc       = 1'b1;
						cmd.has_byte = 1'b1;
						cmd.data     = {nri_q, in_byte[4:0]};
					end
					phase_d = in_byte[6] ? PH_FU_BODY_END : PH_FU_BODY;
				end
				default: ;
			endcase
		end
		if (boundary) begin
			if (bl_d <= LEN_BITS'(2)) begin
				mark    = 1'b1;
				phase_d = PH_SKIP;
			end else begin
				phase_d = PH_AGG_HI;
			end
		end
		if (mark) begin
			cmd.fin = 1'b1;
			if (!cmd.sc && !cmd.has_byte && !cmd.has_stat)
				cmd.has_stat = 1'b1;
		end
		if (bl_d == '0)
			phase_d = PH_IDLE;
		push = accept && (cmd.sc || cmd.has_byte || cmd.has_stat);
	end

endmodule

[hdl/rhd_fifo.sv]
// ----------------------------------------------------------------------------
// rhd_fifo
// Short request queue between parser and emitter.
// ----------------------------------------------------------------------------
module rhd_fifo import rhd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic empty,
	output logic full
);

	cmd_t                mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wp_q, rp_q;
	logic [Q_PTR_BITS:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (Q_PTR_BITS+1)'(Q_DEPTH));
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (Q_PTR_BITS+1)'(push) - (Q_PTR_BITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty) else $error("queue count lost a request");
`endif

endmodule

[hdl/rhd_back.sv]
// ----------------------------------------------------------------------------
// rhd_back
// Emitter: expands each request into start code, data and status results.
// ----------------------------------------------------------------------------
module rhd_back import rhd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        empty,
	output logic        pop,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        out_valid,
	output logic [7:0]  out_data,
	output logic        out_unit_start,
	output logic        out_unit_end,
	output logic [31:0] time_ms,
	output logic [1:0]  status,
	output logic        run_last
);

	logic [2:0] idx_q;
	logic [2:0] n_items;
	logic       last;
	logic       load;
	logic       is_sc;

	assign n_items = (cmd.sc ? 3'd4 : 3'd0) + {2'd0, cmd.has_byte} + {2'd0, cmd.has_stat};
	assign last    = (idx_q == n_items - 3'd1);
	assign load    = !empty && (!res_valid || !res_stall);
	assign pop     = load && last;
	assign is_sc   = cmd.sc && (idx_q < 3'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (!res_valid || !res_stall)
				res_valid <= !empty;
			if (load)
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_valid      <= !cmd.has_stat;
			out_data       <= is_sc ? {7'd0, idx_q == 3'd3} : (cmd.has_stat ? 8'd0 : cmd.data);
			out_unit_start <= is_sc && (idx_q == 3'd0);
			out_unit_end   <= cmd.fin && last;
			time_ms        <= cmd.time_ms;
			status         <= cmd.has_stat ? cmd.status : ST_OK;
			run_last       <= last;
		end
	end

endmodule
